@@ hw/rtl/fpe_pkg.sv @@
package fpe_pkg;

    localparam int unsigned VAL_W     = 8;
    localparam int unsigned MAX_N_DEF = 255;
    localparam int unsigned CNT_W     = $clog2(VAL_W);

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // primes below 256
    function automatic logic is_prime(input logic [VAL_W-1:0] v);
        logic r;
        unique case (v)
            8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23, 8'd29,
            8'd31, 8'd37, 8'd41, 8'd43, 8'd47, 8'd53, 8'd59, 8'd61, 8'd67,
            8'd71, 8'd73, 8'd79, 8'd83, 8'd89, 8'd97, 8'd101, 8'd103, 8'd107,
            8'd109, 8'd113, 8'd127, 8'd131, 8'd137, 8'd139, 8'd149, 8'd151,
            8'd157, 8'd163, 8'd167, 8'd173, 8'd179, 8'd181, 8'd191, 8'd193,
            8'd197, 8'd199, 8'd211, 8'd223, 8'd227, 8'd229, 8'd233, 8'd239,
            8'd241, 8'd251: r = 1'b1;
            default:        r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/fpe_div.sv @@
module fpe_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [fpe_pkg::VAL_W-1:0]     dividend,
    input  logic [fpe_pkg::VAL_W-1:0]     divisor,
    output logic [fpe_pkg::VAL_W-1:0]     quotient,
    output fpe_pkg::div_sts_t             sts
);

    logic [fpe_pkg::VAL_W-1:0] rem_reg, rem_next;
    logic [fpe_pkg::VAL_W-1:0] quot_reg, quot_next;
    logic [fpe_pkg::VAL_W-1:0] dsr_reg, dsr_next;
    logic [fpe_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    logic [fpe_pkg::VAL_W:0]   rem_sh;
    logic [fpe_pkg::VAL_W:0]   diff;
    logic                      ge;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {rem_reg, quot_reg[fpe_pkg::VAL_W-1]};
    assign ge     = rem_sh >= {1'b0, dsr_reg};
    assign diff   = rem_sh - {1'b0, dsr_reg};

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quot_next = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[fpe_pkg::VAL_W-1:0] : rem_sh[fpe_pkg::VAL_W-1:0];
            quot_next = {quot_reg[fpe_pkg::VAL_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == fpe_pkg::CNT_W'(fpe_pkg::VAL_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsr_reg  <= dsr_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = quot_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

@@ hw/rtl/factorial_prime_exponents.sv @@
// channel  dir  tdata                             tlast
// s_       in   n[7:0]                            -
// m_       out  prime[7:0], exponent[15:8]        last prime not above n
//
// an n below 2 is taken with no output word; otherwise the block walks down from n to
// the largest prime, steps up through every value up to that prime, and per prime runs
// a pass (compare, 8 divider steps, result) for each power of p not above n, then one
// closing compare and the output word
// s_tready is high only while idle; a stalled m_ word holds until taken
// synchronous active-low reset returns to idle with no result pending
module factorial_prime_exponents #(
    parameter int unsigned MAX_N = fpe_pkg::MAX_N_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [fpe_pkg::VAL_W-1:0]   s_tdata,   // n[7:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [2*fpe_pkg::VAL_W-1:0] m_tdata,   // prime[7:0], exponent[15:8]
    output logic                        m_tlast
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_TOP   = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_CHECK = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t                    state_reg, state_next;
    logic [fpe_pkg::VAL_W-1:0] n_reg, n_next;
    logic [fpe_pkg::VAL_W-1:0] p_reg, p_next;
    logic [fpe_pkg::VAL_W-1:0] top_reg, top_next;
    logic [fpe_pkg::VAL_W-1:0] q_reg, q_next;
    logic [fpe_pkg::VAL_W-1:0] e_reg, e_next;

    logic [fpe_pkg::VAL_W-1:0] n_sat;
    logic [fpe_pkg::VAL_W:0]   e_sum;
    logic                      div_start;
    logic [fpe_pkg::VAL_W-1:0] div_q;
    fpe_pkg::div_sts_t         div_sts;

    assign n_sat = (32'(s_tdata) > MAX_N) ? fpe_pkg::VAL_W'(MAX_N) : s_tdata;
    assign e_sum = {1'b0, e_reg} + {1'b0, div_q};

    fpe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (q_reg),
        .divisor  (p_reg),
        .quotient (div_q),
        .sts      (div_sts)
    );

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        p_next     = p_reg;
        top_next   = top_reg;
        q_next     = q_reg;
        e_next     = e_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next = n_sat;
                    p_next = n_sat;
                    if (n_sat >= fpe_pkg::VAL_W'(2)) begin
                        state_next = ST_TOP;
                    end
                end
            end
            // walk down from n to the largest prime
            ST_TOP: begin
                if (fpe_pkg::is_prime(p_reg)) begin
                    top_next   = p_reg;
                    p_next     = fpe_pkg::VAL_W'(2);
                    state_next = ST_SCAN;
                end else begin
                    p_next = p_reg - 1'b1;
                end
            end
            ST_SCAN: begin
                if (fpe_pkg::is_prime(p_reg)) begin
                    q_next     = n_reg;
                    e_next     = '0;
                    state_next = ST_CHECK;
                end else begin
                    p_next = p_reg + 1'b1;
                end
            end
            // legendre: q = q / p while q >= p, summing the quotients
            ST_CHECK: begin
                if (q_reg >= p_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    q_next     = div_q;
                    e_next     = e_sum[fpe_pkg::VAL_W] ? '1 : e_sum[fpe_pkg::VAL_W-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (p_reg == top_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        p_next     = p_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        p_reg   <= p_next;
        top_reg <= top_next;
        q_reg   <= q_next;
        e_reg   <= e_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {e_reg, p_reg};
    assign m_tlast  = (p_reg == top_reg);

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("result word shown while input is taken");

    a_word_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> fpe_pkg::is_prime(m_tdata[fpe_pkg::VAL_W-1:0]))
        else $error("result word carries a non-prime");

    a_div_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_sts.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside divide state");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("run did not end after last word");

    a_exp_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2*fpe_pkg::VAL_W-1:fpe_pkg::VAL_W] != '0))
        else $error("prime not above n reported with zero exponent");
`endif

endmodule

@@ test/factorial_prime_exponents_tb.sv @@
`timescale 1ns / 100ps

module factorial_prime_exponents_tb;

    localparam int unsigned VAL_W       = fpe_pkg::VAL_W;
    localparam int unsigned SERVE_MAX   = fpe_pkg::MAX_N_DEF;
    localparam int          IDLE_LIMIT  = 20000;
    localparam int          RANDOM_ITEMS = 360;

    typedef struct packed {
        logic [VAL_W-1:0] prime;
        logic [VAL_W-1:0] exponent;
        logic             last;
    } prime_power_t;

    typedef struct {
        logic [VAL_W-1:0] n;
        bit               drain_first;   // wait for all words of earlier n before sending
        bit               calm;          // no idling on either side while this n runs
    } request_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [VAL_W-1:0]     s_tdata = '0;    // n[7:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [2*VAL_W-1:0]   m_tdata;         // prime[7:0], exponent[15:8]
    logic                 m_tlast;

    request_t     request_q[$];
    prime_power_t factor_q[$];
    logic         drained = 1'b1;
    bit           calm = 1'b0;
    int           send_gap = 0;
    int           ready_wait = 0;
    int           idle_run = 0;
    int           mismatches = 0;
    int           words_checked = 0;
    int           n_sent = 0;
    int           n_without_primes = 0;
    int           drain_pauses = 0;

    factorial_prime_exponents #(.MAX_N(SERVE_MAX)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit has_no_divisor(input int v);
        if (v < 2) begin
            return 1'b0;
        end
        for (int d = 2; d * d <= v; d++) begin
            if (v % d == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic int idle_draw();
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    // legendre sum per prime, largest prime flagged
    task automatic predict_factorization(input logic [VAL_W-1:0] n);
        int           lim;
        int           top;
        int           q;
        int           e;
        prime_power_t w;
        lim = (n > SERVE_MAX) ? SERVE_MAX : n;
        top = 0;
        for (int p = 2; p <= lim; p++) begin
            if (has_no_divisor(p)) top = p;
        end
        for (int p = 2; p <= lim; p++) begin
            if (!has_no_divisor(p)) continue;
            q = lim;
            e = 0;
            while (q >= p) begin
                q = q / p;
                e = e + q;
            end
            w.prime    = p[VAL_W-1:0];
            w.exponent = (e > 255) ? 8'd255 : e[VAL_W-1:0];
            w.last     = (p == top);
            factor_q = {factor_q, w};
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // driver
    always @(posedge aclk) begin
        logic     next_valid;
        request_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                next_valid = 1'b0;
                send_gap = idle_draw();
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_q.size() != 0 &&
                             !(request_q[0].drain_first && (s_tvalid || !drained))) begin
                    r = request_q.pop_front();
                    calm = r.calm;
                    if (r.drain_first) drain_pauses++;
                    s_tdata <= r.n;
                    next_valid = 1'b1;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // monitor: predicts on each accepted n, checks each accepted word
    always @(posedge aclk) begin
        logic         next_ready;
        prime_power_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_wait = idle_draw();
        end else begin
            if (s_tvalid && s_tready) begin
                n_sent++;
                if (s_tdata < 2) n_without_primes++;
                predict_factorization(s_tdata);
            end
            next_ready = m_tready;
            if (m_tvalid && m_tready) begin
                if (factor_q.size() == 0) begin
                    report("unexpected word, prime", m_tdata[VAL_W-1:0], 0);
                end else begin
                    want = factor_q.pop_front();
                    words_checked++;
                    if (m_tdata[VAL_W-1:0] !== want.prime)
                        report("prime", m_tdata[VAL_W-1:0], want.prime);
                    if (m_tdata[2*VAL_W-1:VAL_W] !== want.exponent)
                        report("exponent", m_tdata[2*VAL_W-1:VAL_W], want.exponent);
                    if (m_tlast !== want.last)
                        report("tlast", m_tlast, want.last);
                end
                ready_wait = idle_draw();
                next_ready = (ready_wait == 0);
            end else if (!m_tready) begin
                if (ready_wait > 0) ready_wait--;
                next_ready = (ready_wait == 0);
            end
            m_tready <= next_ready;
            drained  <= (factor_q.size() == 0);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_run <= 0;
        end else if (idle_run >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    initial begin
        int       directed[] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 11, 16, 31, 32, 64, 85, 127,
                                 128, 170, 250, 251, 252, 253, 254, 255};
        request_t r;
        int       k;

        foreach (directed[i]) begin
            r.n           = VAL_W'(directed[i]);
            r.drain_first = (i == 12);
            r.calm        = 1'b0;
            request_q = {request_q, r};
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: r.n = VAL_W'($urandom_range(0, 255));
                4, 5, 6:    r.n = VAL_W'($urandom_range(0, 31));
                7:          r.n = VAL_W'($urandom_range(240, 255));
                8:          r.n = VAL_W'($urandom_range(0, 1));
                default: begin
                    k = 1 << $urandom_range(1, 7);
                    r.n = VAL_W'(k + int'($urandom_range(0, 2)) - 1);
                end
            endcase
            r.drain_first = (i % 60 == 0);
            r.calm        = (i >= 100 && i < 140) || (i >= 250 && i < 280);
            request_q = {request_q, r};
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_q.size() != 0 || s_tvalid || !drained) @(posedge aclk);
        repeat (60) @(posedge aclk);

        if (factor_q.size() != 0)
            report("words never delivered", 0, factor_q.size());

        $display("sent %0d values of n (%0d below 2), checked %0d prime/exponent words",
                 n_sent, n_without_primes, words_checked);
        $display("drained the pipe before sending %0d times, %0d mismatches",
                 drain_pauses, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
